// ===== hdl/ultrasonic_echo_ranger_assert.svh =====
// ----------------------------------------------------------------------------
// Ultrasonic echo ranger assertion macros
// Shorthand for the clocked, reset-qualified checks used in the ranger RTL.
// ----------------------------------------------------------------------------
`ifndef ULTRASONIC_ECHO_RANGER_ASSERT_SVH
`define ULTRASONIC_ECHO_RANGER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define UER_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define UER_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/uer_pkg.sv =====
// ----------------------------------------------------------------------------
// Ultrasonic echo ranger package
// Phase and request codes, register indexes, reset values and distance scaling.
// ----------------------------------------------------------------------------
package uer_pkg;

  // Default width of the echo counter.
  localparam int COUNT_WIDTH_DEF = 16;

  // Field widths.
  localparam int KIND_W     = 2;
  localparam int BURST_W    = 12;
  localparam int BLIND_W    = 12;
  localparam int PERIOD_W   = 16;
  localparam int STALE_W    = 16;
  localparam int PCOUNT_W   = 12;
  localparam int ETIME_W    = 16;
  localparam int DIST_W     = 15;
  localparam int FLIGHT_W   = 17;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int IN_DATA_W  = 8;
  localparam int OUT_DATA_W = 40;

  // Request kinds.
  localparam logic [KIND_W-1:0] KIND_TICK  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_START = 2'd1;
  localparam logic [KIND_W-1:0] KIND_POLL  = 2'd2;

  // Measurement phases.
  localparam logic [1:0] PH_IDLE   = 2'd0;
  localparam logic [1:0] PH_TX     = 2'd1;
  localparam logic [1:0] PH_BLIND  = 2'd2;
  localparam logic [1:0] PH_LISTEN = 2'd3;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_BURST  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BLIND  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PERIOD = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_STALE  = 2'd3;

  // Register reset values.
  localparam logic [BURST_W-1:0]  BURST_RST  = 12'd500;
  localparam logic [BLIND_W-1:0]  BLIND_RST  = 12'd250;
  localparam logic [PERIOD_W-1:0] PERIOD_RST = 16'd5000;
  localparam logic [STALE_W-1:0]  STALE_RST  = 16'd300;

  localparam logic [STALE_W-1:0] STALE_MAX = '1;

  // Distance in 1/16 cm is floor(flight * 16 / 58) = floor(flight * 8 / 29).
  // With a 21-bit reciprocal of 29 scaled by 2^25 the product is exact for
  // every 17-bit flight time; the factor 8 folds into the shift: 25 - 3 = 22.
  localparam int DIST_RECIP_W = 21;
  localparam logic [DIST_RECIP_W-1:0] DIST_RECIP = 21'd1157050;
  localparam int DIST_SHIFT = 22;
  localparam int DIST_PROD_W = FLIGHT_W + DIST_RECIP_W;

endpackage

// ===== hdl/ultrasonic_echo_ranger.sv =====
// ----------------------------------------------------------------------------
// Ultrasonic echo ranger
// Time-of-flight ranging from microsecond ticks, start requests and polls.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Signals                         Contents
//  s_*       in         s_tvalid s_tready s_tdata s_tuser  one tick, start or poll
//  m_*       out        m_tvalid m_tready m_tdata          one status result
//  cfg_*     in         cfg_wr_en cfg_index cfg_data       register writes
//
// Every request yields exactly one result, and one request is taken per clock
// while m_tready is high. A request is held in the input register, and the
// phase logic, the echo counter and the distance multiplier turn it into the
// result register.
// Reset (rst, synchronous) loads the register defaults and leaves the ranger
// idle with no valid request or result.
// While m_tready is low the result holds; the input register takes one more
// request and then s_tready falls until the result moves on.
//
// Each measurement walks through the transmit gate, the blind time (skipped
// when blind_ticks is zero) and the listening window. While listening,
// every falling echo edge captures the wrapping echo counter and raises
// capture_ready. A poll that finds a capture converts blind time plus capture
// into a distance and restarts; a poll that finds none counts toward the stale
// limit, past which the distance is zeroed and the measurement restarts.
// ----------------------------------------------------------------------------
`include "ultrasonic_echo_ranger_assert.svh"

module ultrasonic_echo_ranger
  import uer_pkg::*;
#(
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  // Request stream.
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [IN_DATA_W-1:0]  s_tdata,   // [0] echo_level, [7:1] zero
  input  logic [KIND_W-1:0]     s_tuser,   // [1:0] kind
  // Result stream.
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata,   // [0] tx_on, [1] listening,
                                           // [2] capture_ready, [18:3] echo_time,
                                           // [33:19] distance, [34] distance_fresh,
                                           // [39:35] zero
  // Configuration writes.
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  // Width used to compare the echo counter with the 16-bit period.
  localparam int CMP_W = (COUNT_WIDTH > PERIOD_W) ? COUNT_WIDTH : PERIOD_W;

  // Configuration registers.
  logic [BURST_W-1:0]  burst_ticks;
  logic [BLIND_W-1:0]  blind_ticks;
  logic [PERIOD_W-1:0] echo_period;
  logic [STALE_W-1:0]  stale_limit;

  // Input register.
  logic              in_valid;
  logic [KIND_W-1:0] in_kind;
  logic              in_level;

  // Measurement state.
  logic [1:0]             phase,         phase_next;
  logic [PCOUNT_W-1:0]    phase_count,   phase_count_next;
  logic [COUNT_WIDTH-1:0] echo_counter,  echo_counter_next;
  logic [ETIME_W-1:0]     captured_time, captured_time_next;
  logic                   ready_flag,    ready_flag_next;
  logic                   prev_echo,     prev_echo_next;
  logic [DIST_W-1:0]      last_distance, last_distance_next;
  logic [STALE_W-1:0]     stale_count,   stale_count_next;
  logic                   fresh_next;

  // Result register.
  logic                   out_valid;
  logic                   out_tx_on;
  logic                   out_listening;
  logic                   out_ready;
  logic [ETIME_W-1:0]     out_echo_time;
  logic [DIST_W-1:0]      out_distance;
  logic                   out_fresh;

  // Datapath terms.
  logic                   advance;
  logic [PCOUNT_W-1:0]    pc_inc;
  logic [COUNT_WIDTH-1:0] cnt_inc;
  logic                   cnt_wrap;
  logic [FLIGHT_W-1:0]    flight;
  logic [DIST_PROD_W-1:0] dist_prod;
  logic [DIST_W-1:0]      dist_calc;
  logic [STALE_W-1:0]     stale_inc;

  // The request in the input register moves to the result register whenever
  // the result register is empty or being emptied this cycle.
  assign advance  = in_valid && (!out_valid || m_tready);
  assign s_tready = !in_valid || advance;

  // Configuration writes land directly; the user must issue them only while idle, as the block does not enforce it.
  always_ff @(posedge clk) begin
    if (rst) begin
      burst_ticks <= BURST_RST;
      blind_ticks <= BLIND_RST;
      echo_period <= PERIOD_RST;
      stale_limit <= STALE_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_BURST:  burst_ticks <= cfg_data[BURST_W-1:0];
        REG_BLIND:  blind_ticks <= cfg_data[BLIND_W-1:0];
        REG_PERIOD: echo_period <= cfg_data[PERIOD_W-1:0];
        REG_STALE:  stale_limit <= cfg_data[STALE_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_kind  <= s_tuser;
      in_level <= s_tdata[0];
    end
  end

  // Shared increments and the distance conversion.
  assign pc_inc   = phase_count + PCOUNT_W'(1);
  assign cnt_inc  = echo_counter + COUNT_WIDTH'(1);
  assign cnt_wrap = (echo_period != '0) && (CMP_W'(cnt_inc) >= CMP_W'(echo_period));
  assign flight   = FLIGHT_W'(blind_ticks) + FLIGHT_W'(captured_time);
  assign dist_prod = DIST_PROD_W'(flight) * DIST_PROD_W'(DIST_RECIP);
  assign dist_calc = dist_prod[DIST_SHIFT +: DIST_W];
  assign stale_inc = (stale_count == STALE_MAX) ? stale_count
                                                : stale_count + STALE_W'(1);

  always_comb begin
    phase_next         = phase;
    phase_count_next   = phase_count;
    echo_counter_next  = echo_counter;
    captured_time_next = captured_time;
    ready_flag_next    = ready_flag;
    prev_echo_next     = prev_echo;
    last_distance_next = last_distance;
    stale_count_next   = stale_count;
    fresh_next         = 1'b0;

    case (in_kind)
      KIND_TICK: begin
        prev_echo_next = in_level;
        case (phase)
          PH_TX: begin
            // A zero burst length behaves as one tick, as pc_inc >= burst_ticks always holds.
            if (pc_inc >= burst_ticks || pc_inc == '0) begin
              phase_count_next = '0;
              if (blind_ticks == '0) begin
                phase_next        = PH_LISTEN;
                echo_counter_next = '0;
              end else begin
                phase_next = PH_BLIND;
              end
            end else begin
              phase_count_next = pc_inc;
            end
          end
          PH_BLIND: begin
            if (pc_inc >= blind_ticks || pc_inc == '0) begin
              phase_next        = PH_LISTEN;
              phase_count_next  = '0;
              echo_counter_next = '0;
            end else begin
              phase_count_next = pc_inc;
            end
          end
          PH_LISTEN: begin
            if (prev_echo && !in_level) begin
              captured_time_next = ETIME_W'(echo_counter);
              ready_flag_next    = 1'b1;
            end
            echo_counter_next = cnt_wrap ? '0 : cnt_inc;
          end
          default: ;
        endcase
      end
      KIND_START: begin
        ready_flag_next    = 1'b0;
        captured_time_next = '0;
        phase_count_next   = '0;
        phase_next         = PH_TX;
      end
      KIND_POLL: begin
        if (ready_flag) begin
          last_distance_next = dist_calc;
          stale_count_next   = '0;
          fresh_next         = 1'b1;
          ready_flag_next    = 1'b0;
          captured_time_next = '0;
          phase_count_next   = '0;
          phase_next         = PH_TX;
        end else if (stale_inc > stale_limit) begin
          // Stale timeout: invalidate the distance and measure again.
          last_distance_next = '0;
          stale_count_next   = '0;
          ready_flag_next    = 1'b0;
          captured_time_next = '0;
          phase_count_next   = '0;
          phase_next         = PH_TX;
        end else begin
          stale_count_next = stale_inc;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      phase_count   <= '0;
      echo_counter  <= '0;
      captured_time <= '0;
      ready_flag    <= 1'b0;
      prev_echo     <= 1'b1;
      last_distance <= '0;
      stale_count   <= '0;
    end else if (advance) begin
      phase         <= phase_next;
      phase_count   <= phase_count_next;
      echo_counter  <= echo_counter_next;
      captured_time <= captured_time_next;
      ready_flag    <= ready_flag_next;
      prev_echo     <= prev_echo_next;
      last_distance <= last_distance_next;
      stale_count   <= stale_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_tx_on     <= (phase_next == PH_TX);
      out_listening <= (phase_next == PH_LISTEN);
      out_ready     <= ready_flag_next;
      out_echo_time <= captured_time_next;
      out_distance  <= last_distance_next;
      out_fresh     <= fresh_next;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {5'b0, out_fresh, out_distance, out_echo_time,
                     out_ready, out_listening, out_tx_on};

  // A capture can only be pending inside the listening window.
  `UER_ASSERT_SAME(a_ready_in_listen, ready_flag, phase == PH_LISTEN,
                   "capture pending outside listening phase")
  // The phase counter is unused and held at zero while listening.
  `UER_ASSERT_SAME(a_listen_count_zero, phase == PH_LISTEN, phase_count == '0,
                   "phase counter not zero while listening")
  // Once a measurement has started the ranger never goes back to idle.
  `UER_ASSERT_NEXT(a_no_return_idle, phase != PH_IDLE, phase != PH_IDLE,
                   "phase returned to idle")
  // A fresh distance always comes with a restarted measurement.
  `UER_ASSERT_SAME(a_fresh_restarts, m_tvalid && out_fresh, out_tx_on && !out_ready,
                   "fresh distance without restart")
  // A request waiting in the input register is never dropped.
  `UER_ASSERT_NEXT(a_input_held, in_valid && !advance, in_valid,
                   "pending request lost")

endmodule
